// ===== src/trcf_pkg.sv =====
// Shared types and constants for the triangle region clip filter.
// Used by the interfaces, controller, datapath and top level; no dependencies.
package trcf_pkg;

	localparam int FIELD_W          = 32;
	localparam int MAX_BOUNDARY_DEF = 64;
	localparam int MAX_HOLES_DEF    = 16;
	localparam int COORD_BITS_DEF   = 32;
	localparam logic [1:0] TRI_LAST_EDGE = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_B = 2'd0,
		CMD_LOAD_H = 2'd1,
		CMD_TEST   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_FEW  = 2'd2
	} stat_e_t;

	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_FULL = 2'd1,
		RES_FEW  = 2'd2,
		RES_TEST = 2'd3
	} res_kind_t;

	typedef struct packed {
		logic      capture;
		logic      b_write;
		logic      h_write;
		logic      clear;
		logic      idx_clr;
		logic      test_clr;
		logic      b_rd;
		logic      b_rd_last;
		logic      load_prev;
		logic      load_cur;
		logic      b_adv;
		logic      setup_edge;
		logic      setup_tri;
		logic [1:0] tri_edge;
		logic      mul_en;
		logic [1:0] mul_step;
		logic      edge_eval;
		logic      h_rd;
		logic      h_adv;
		logic      tri_clr;
		logic      tri_eval;
		logic      set_hit;
		logic      res_write;
		res_kind_t res_kind;
	} dp_cmd_t;

	typedef struct packed {
		cmd_e_t cmd_code;
		logic   b_full;
		logic   h_full;
		logic   b_few;
		logic   b_last;
		logic   h_empty;
		logic   h_last;
		logic   on_edge;
		logic   tri_hit;
	} dp_stat_t;

endpackage

// ===== src/trcf_if.sv =====
// Handshake interfaces for the input word and the result word.
// Depends on trcf_pkg for the field width.
interface trcf_item_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          command;
	logic signed [trcf_pkg::FIELD_W-1:0] ax;
	logic signed [trcf_pkg::FIELD_W-1:0] ay;
	logic signed [trcf_pkg::FIELD_W-1:0] bx;
	logic signed [trcf_pkg::FIELD_W-1:0] by_coord;
	logic signed [trcf_pkg::FIELD_W-1:0] cx;
	logic signed [trcf_pkg::FIELD_W-1:0] cy;
	modport source (output valid, command, ax, ay, bx, by_coord, cx, cy, input ready);
	modport sink (input valid, command, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface trcf_result_if;
	logic       valid;
	logic       ready;
	logic       keep;
	logic       centroid_inside;
	logic       hole_hit;
	logic [1:0] status;
	modport source (output valid, keep, centroid_inside, hole_hit, status, input ready);
	modport sink (input valid, keep, centroid_inside, hole_hit, status, output ready);
endinterface

// ===== src/trcf_ctrl.sv =====
// Controller state machine: sequences loads, the boundary edge walk and the hole walk.
// Depends on trcf_pkg for command and status structs.
module trcf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  trcf_pkg::dp_stat_t st,
	output trcf_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_B_PREV, S_B_RD, S_B_CUR, S_B_SETUP, S_MUL, S_B_EVAL,
		S_H_RD, S_H_CUR, S_H_SETUP, S_H_EVAL, S_FIN
	} state_t;

	state_t              state_q, state_d;
	logic [1:0]          step_q, step_d;
	logic [1:0]          edge_q, edge_d;
	logic                hmode_q, hmode_d;
	trcf_pkg::res_kind_t kind_q, kind_d;
	logic                out_valid_q, out_valid_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		step_d      = step_q;
		edge_d      = edge_q;
		hmode_d     = hmode_q;
		kind_d      = kind_q;
		cmd.res_kind = kind_q;
		cmd.tri_edge = edge_q;
		cmd.mul_step = step_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				kind_d  = trcf_pkg::RES_NONE;
				unique case (st.cmd_code)
					trcf_pkg::CMD_LOAD_B: begin
						if (st.b_full) kind_d = trcf_pkg::RES_FULL;
						else cmd.b_write = 1'b1;
					end
					trcf_pkg::CMD_LOAD_H: begin
						if (st.h_full) kind_d = trcf_pkg::RES_FULL;
						else cmd.h_write = 1'b1;
					end
					trcf_pkg::CMD_CLEAR: begin
						cmd.clear = 1'b1;
					end
					trcf_pkg::CMD_TEST: begin
						if (st.b_few) begin
							kind_d = trcf_pkg::RES_FEW;
						end else begin
							kind_d        = trcf_pkg::RES_TEST;
							cmd.b_rd      = 1'b1;
							cmd.b_rd_last = 1'b1;
							cmd.idx_clr   = 1'b1;
							cmd.test_clr  = 1'b1;
							state_d       = S_B_PREV;
						end
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_B_PREV: begin
				cmd.load_prev = 1'b1;
				cmd.b_rd      = 1'b1;
				state_d       = S_B_CUR;
			end
			S_B_RD: begin
				cmd.b_rd = 1'b1;
				state_d  = S_B_CUR;
			end
			S_B_CUR: begin
				cmd.load_cur = 1'b1;
				state_d      = S_B_SETUP;
			end
			S_B_SETUP: begin
				cmd.setup_edge = 1'b1;
				hmode_d        = 1'b0;
				step_d         = '0;
				state_d        = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				step_d     = step_q + 2'd1;
				if (step_q == 2'd3) state_d = hmode_q ? S_H_EVAL : S_B_EVAL;
			end
			S_B_EVAL: begin
				cmd.edge_eval = 1'b1;
				if (st.on_edge || st.b_last) begin
					state_d = st.h_empty ? S_FIN : S_H_RD;
				end else begin
					cmd.b_adv = 1'b1;
					state_d   = S_B_RD;
				end
			end
			S_H_RD: begin
				cmd.h_rd = 1'b1;
				state_d  = S_H_CUR;
			end
			S_H_CUR: begin
				cmd.tri_clr = 1'b1;
				edge_d      = '0;
				state_d     = S_H_SETUP;
			end
			S_H_SETUP: begin
				cmd.setup_tri = 1'b1;
				hmode_d       = 1'b1;
				step_d        = '0;
				state_d       = S_MUL;
			end
			S_H_EVAL: begin
				cmd.tri_eval = 1'b1;
				if (edge_q != trcf_pkg::TRI_LAST_EDGE) begin
					edge_d  = edge_q + 2'd1;
					state_d = S_H_SETUP;
				end else if (st.tri_hit) begin
					cmd.set_hit = 1'b1;
					state_d     = S_FIN;
				end else if (st.h_last) begin
					state_d = S_FIN;
				end else begin
					cmd.h_adv = 1'b1;
					state_d   = S_H_RD;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_write = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cmd.res_write) out_valid_d = 1'b1;
		else if (out_ready) out_valid_d = 1'b0;
		else out_valid_d = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			edge_q      <= '0;
			hmode_q     <= 1'b0;
			kind_q      <= trcf_pkg::RES_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			edge_q      <= edge_d;
			hmode_q     <= hmode_d;
			kind_q      <= kind_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

// ===== src/trcf_dpath.sv =====
// Datapath: point stores, operand registers, shared split multiplier and result register.
// Depends on trcf_pkg; driven by trcf_ctrl through dp_cmd_t.
module trcf_dpath #(
	parameter int MAX_BOUNDARY = trcf_pkg::MAX_BOUNDARY_DEF,
	parameter int MAX_HOLES    = trcf_pkg::MAX_HOLES_DEF,
	parameter int COORD_BITS   = trcf_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          command,
	input  logic signed [trcf_pkg::FIELD_W-1:0] ax,
	input  logic signed [trcf_pkg::FIELD_W-1:0] ay,
	input  logic signed [trcf_pkg::FIELD_W-1:0] bx,
	input  logic signed [trcf_pkg::FIELD_W-1:0] by_coord,
	input  logic signed [trcf_pkg::FIELD_W-1:0] cx,
	input  logic signed [trcf_pkg::FIELD_W-1:0] cy,
	input  trcf_pkg::dp_cmd_t                   cmd,
	output trcf_pkg::dp_stat_t                  st,
	output logic                                keep,
	output logic                                centroid_inside,
	output logic                                hole_hit,
	output logic [1:0]                          status
);

	localparam int CW  = COORD_BITS;
	localparam int SW  = CW + 2;
	localparam int DW  = CW + 3;
	localparam int LO  = DW / 2;
	localparam int HI  = DW - LO;
	localparam int PW  = 2 * DW;
	localparam int BAW = $clog2(MAX_BOUNDARY);
	localparam int BCW = $clog2(MAX_BOUNDARY + 1);
	localparam int HAW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int HCW = $clog2(MAX_HOLES + 1);

	logic signed [CW-1:0] ax_c, ay_c, bx_c, by_c, cx_c, cy_c;
	assign ax_c = ax[CW-1:0];
	assign ay_c = ay[CW-1:0];
	assign bx_c = bx[CW-1:0];
	assign by_c = by_coord[CW-1:0];
	assign cx_c = cx[CW-1:0];
	assign cy_c = cy[CW-1:0];

	trcf_pkg::cmd_e_t     cmd_q;
	logic signed [CW-1:0] a_x_q, a_y_q, b_x_q, b_y_q, c_x_q, c_y_q;
	logic signed [SW-1:0] px_q, py_q;

	logic [2*CW-1:0] bmem [MAX_BOUNDARY];
	logic [2*CW-1:0] hmem [MAX_HOLES];
	logic [2*CW-1:0] brd_q, hrd_q;
	logic [BCW-1:0]  bcnt_q;
	logic [HCW-1:0]  hcnt_q;
	logic [BAW-1:0]  b_idx_q, b_raddr;
	logic [HAW-1:0]  h_idx_q;

	logic signed [SW-1:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic signed [CW-1:0] br_x, br_y, hp_x, hp_y;
	logic signed [DW-1:0] p_q, q_q, r_q, s_q;
	logic signed [PW-1:0] acc_q, term;
	logic signed [DW-1:0] m_a, m_b;
	logic signed [HI:0]   b_part;
	logic signed [DW+HI:0] prod;
	logic                 acc_neg, acc_zero, acc_pos, straddle, left, on_edge;
	logic                 cin_q, hit_q, neg_q, pos_q;
	logic signed [CW-1:0] ux, uy, vx, vy;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= trcf_pkg::cmd_e_t'(command);
			a_x_q <= ax_c;
			a_y_q <= ay_c;
			b_x_q <= bx_c;
			b_y_q <= by_c;
			c_x_q <= cx_c;
			c_y_q <= cy_c;
			px_q  <= SW'(ax_c) + SW'(bx_c) + SW'(cx_c);
			py_q  <= SW'(ay_c) + SW'(by_c) + SW'(cy_c);
		end
	end

	assign b_raddr = cmd.b_rd_last ? BAW'(bcnt_q - BCW'(1)) : b_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.b_write) bmem[bcnt_q[BAW-1:0]] <= {a_x_q, a_y_q};
		if (cmd.b_rd) brd_q <= bmem[b_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.h_write) hmem[hcnt_q[HAW-1:0]] <= {a_x_q, a_y_q};
		if (cmd.h_rd) hrd_q <= hmem[h_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q  <= '0;
			hcnt_q  <= '0;
			b_idx_q <= '0;
			h_idx_q <= '0;
		end else begin
			if (cmd.clear) begin
				bcnt_q <= '0;
				hcnt_q <= '0;
			end
			if (cmd.b_write) bcnt_q <= bcnt_q + BCW'(1);
			if (cmd.h_write) hcnt_q <= hcnt_q + HCW'(1);
			if (cmd.idx_clr) begin
				b_idx_q <= '0;
				h_idx_q <= '0;
			end
			if (cmd.b_adv) b_idx_q <= b_idx_q + BAW'(1);
			if (cmd.h_adv) h_idx_q <= h_idx_q + HAW'(1);
		end
	end

	assign br_x = brd_q[2*CW-1:CW];
	assign br_y = brd_q[CW-1:0];
	assign hp_x = hrd_q[2*CW-1:CW];
	assign hp_y = hrd_q[CW-1:0];

	always_comb begin
		case (cmd.tri_edge)
			2'd1: begin
				ux = b_x_q; uy = b_y_q; vx = c_x_q; vy = c_y_q;
			end
			2'd2: begin
				ux = c_x_q; uy = c_y_q; vx = a_x_q; vy = a_y_q;
			end
			default: begin
				ux = a_x_q; uy = a_y_q; vx = b_x_q; vy = b_y_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_prev) begin
			prev_x_q <= (SW'(br_x) <<< 1) + SW'(br_x);
			prev_y_q <= (SW'(br_y) <<< 1) + SW'(br_y);
		end else if (cmd.b_adv) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (cmd.load_cur) begin
			cur_x_q <= (SW'(br_x) <<< 1) + SW'(br_x);
			cur_y_q <= (SW'(br_y) <<< 1) + SW'(br_y);
		end
		if (cmd.setup_edge) begin
			p_q <= DW'(prev_x_q) - DW'(cur_x_q);
			q_q <= DW'(py_q) - DW'(cur_y_q);
			r_q <= DW'(prev_y_q) - DW'(cur_y_q);
			s_q <= DW'(px_q) - DW'(cur_x_q);
		end else if (cmd.setup_tri) begin
			p_q <= DW'(vx) - DW'(ux);
			q_q <= DW'(hp_y) - DW'(uy);
			r_q <= DW'(vy) - DW'(uy);
			s_q <= DW'(hp_x) - DW'(ux);
		end
	end

	assign m_a    = cmd.mul_step[1] ? r_q : p_q;
	assign m_b    = cmd.mul_step[1] ? s_q : q_q;
	assign b_part = cmd.mul_step[0] ? $signed({m_b[DW-1], m_b[DW-1:LO]})
	                                : $signed({{(HI + 1 - LO){1'b0}}, m_b[LO-1:0]});
	assign prod   = m_a * b_part;
	assign term   = cmd.mul_step[0] ? (PW'(prod) <<< LO) : PW'(prod);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			if (cmd.mul_step == 2'd0) acc_q <= term;
			else if (cmd.mul_step[1]) acc_q <= acc_q - term;
			else acc_q <= acc_q + term;
		end
	end

	assign acc_neg  = acc_q[PW-1];
	assign acc_zero = (acc_q == '0);
	assign acc_pos  = !acc_neg && !acc_zero;
	assign on_edge  = acc_zero
	               && (px_q >= cur_x_q || px_q >= prev_x_q)
	               && (px_q <= cur_x_q || px_q <= prev_x_q)
	               && (py_q >= cur_y_q || py_q >= prev_y_q)
	               && (py_q <= cur_y_q || py_q <= prev_y_q);
	assign straddle = (cur_y_q > py_q) != (prev_y_q > py_q);
	assign left     = straddle && (r_q[DW-1] ? acc_neg : acc_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cin_q <= 1'b0;
			hit_q <= 1'b0;
			neg_q <= 1'b0;
			pos_q <= 1'b0;
		end else begin
			if (cmd.test_clr) begin
				cin_q <= 1'b0;
				hit_q <= 1'b0;
			end
			if (cmd.edge_eval) begin
				if (on_edge) cin_q <= 1'b1;
				else if (left) cin_q <= !cin_q;
			end
			if (cmd.set_hit) hit_q <= 1'b1;
			if (cmd.tri_clr) begin
				neg_q <= 1'b0;
				pos_q <= 1'b0;
			end else if (cmd.tri_eval) begin
				neg_q <= neg_q | acc_neg;
				pos_q <= pos_q | acc_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_write) begin
			unique case (cmd.res_kind)
				trcf_pkg::RES_FULL: begin
					keep <= 1'b0; centroid_inside <= 1'b0; hole_hit <= 1'b0;
					status <= trcf_pkg::STAT_FULL;
				end
				trcf_pkg::RES_FEW: begin
					keep <= 1'b1; centroid_inside <= 1'b0; hole_hit <= 1'b0;
					status <= trcf_pkg::STAT_FEW;
				end
				trcf_pkg::RES_TEST: begin
					keep <= cin_q && !hit_q; centroid_inside <= cin_q; hole_hit <= hit_q;
					status <= trcf_pkg::STAT_OK;
				end
				default: begin
					keep <= 1'b0; centroid_inside <= 1'b0; hole_hit <= 1'b0;
					status <= trcf_pkg::STAT_OK;
				end
			endcase
		end
	end

	assign st.cmd_code = cmd_q;
	assign st.b_full   = (bcnt_q == BCW'(MAX_BOUNDARY));
	assign st.h_full   = (hcnt_q == HCW'(MAX_HOLES));
	assign st.b_few    = (bcnt_q < BCW'(3));
	assign st.b_last   = (BCW'(b_idx_q) == bcnt_q - BCW'(1));
	assign st.h_empty  = (hcnt_q == '0);
	assign st.h_last   = (HCW'(h_idx_q) == hcnt_q - HCW'(1));
	assign st.on_edge  = on_edge;
	assign st.tri_hit  = !((neg_q | acc_neg) && (pos_q | acc_pos));

endmodule

// ===== src/triangle_region_clip_filter_top.sv =====
// Top level of the triangle region clip filter: controller plus datapath.
// Depends on trcf_pkg, trcf_if, trcf_ctrl and trcf_dpath.
//
// Usage: every input word on item carries a command. Load boundary vertex and
// load hole seed append (ax, ay) to their store, or report status full and drop
// it. Clear empties both stores. Test triangle classifies (ax,ay),(bx,by_coord),
// (cx,cy) against the stored boundary and holes. Every input word gives exactly
// one result word on result.
// Sequence: a load or clear goes from decode straight to the result. A test
// walks Nb boundary edges (up to the count, less when the centroid lands on
// an edge), then checks Nh hole seeds against the triangle's edges (up to the
// count, less on the first hit). Each cross product is built from four partial
// products in the one shared split multiplier. One word is in work at a time.
// Reset clears both store counts; store contents are undefined and never read.
// A finished result waits in the output register while the next word is accepted;
// a stalled receiver holds the block only when the next result is ready.
module triangle_region_clip_filter_top #(
	parameter int MAX_BOUNDARY = trcf_pkg::MAX_BOUNDARY_DEF,
	parameter int MAX_HOLES    = trcf_pkg::MAX_HOLES_DEF,
	parameter int COORD_BITS   = trcf_pkg::COORD_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	trcf_item_if.sink     item,
	trcf_result_if.source result
);

	trcf_pkg::dp_cmd_t  cmd;
	trcf_pkg::dp_stat_t st;

	trcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.cmd       (cmd)
	);

	trcf_dpath #(
		.MAX_BOUNDARY (MAX_BOUNDARY),
		.MAX_HOLES    (MAX_HOLES),
		.COORD_BITS   (COORD_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.command         (item.command),
		.ax              (item.ax),
		.ay              (item.ay),
		.bx              (item.bx),
		.by_coord        (item.by_coord),
		.cx              (item.cx),
		.cy              (item.cy),
		.cmd             (cmd),
		.st              (st),
		.keep            (result.keep),
		.centroid_inside (result.centroid_inside),
		.hole_hit        (result.hole_hit),
		.status          (result.status)
	);

endmodule

// ===== src/trcf_checker.sv =====
// Port-level checks for the triangle region clip filter top level.
// Bound to triangle_region_clip_filter_top; no package dependency.
module trcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic       result_keep,
	input logic       result_cin,
	input logic       result_hit,
	input logic [1:0] result_status
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable({result_keep, result_cin, result_hit,
			result_status}))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("accepted a second word while busy");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !result_valid |=> !result_valid)
		else $error("result appeared one cycle after accept");

endmodule

bind triangle_region_clip_filter_top trcf_checker u_trcf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_keep   (result.keep),
	.result_cin    (result.centroid_inside),
	.result_hit    (result.hole_hit),
	.result_status (result.status)
);
